// ===== hw/rtl/fhm_pkg.sv =====
`default_nettype none
package fhm_pkg;

  // widths of the homography entries and the intermediate terms
  localparam int HW       = 48;
  localparam int NH       = 8;
  localparam int HALF     = 24;
  localparam int PPW      = 50;
  localparam int TW       = 97;
  localparam int MW       = 96;
  localparam int QW       = 64;
  localparam int FW       = 32;
  localparam int DIV_SH   = 32;
  localparam int SRW      = 34;

  // pipeline depths
  localparam int FRONT_STAGES = 3;
  localparam int DIV_STAGES   = QW;
  localparam int SQ_STAGES    = FW;
  localparam int LAT          = FRONT_STAGES + 2 + DIV_STAGES + 1 + SQ_STAGES;

  // entry indexes of the homography word
  localparam logic [2:0] H00 = 3'd0;
  localparam logic [2:0] H01 = 3'd1;
  localparam logic [2:0] H02 = 3'd2;
  localparam logic [2:0] H10 = 3'd3;
  localparam logic [2:0] H11 = 3'd4;
  localparam logic [2:0] H12 = 3'd5;
  localparam logic [2:0] H20 = 3'd6;
  localparam logic [2:0] H21 = 3'd7;

  // products needed by either camera
  localparam int NPROD = 14;
  localparam int P_00_01 = 0;
  localparam int P_10_11 = 1;
  localparam int P_00_00 = 2;
  localparam int P_10_10 = 3;
  localparam int P_01_01 = 4;
  localparam int P_11_11 = 5;
  localparam int P_20_21 = 6;
  localparam int P_21_21 = 7;
  localparam int P_20_20 = 8;
  localparam int P_00_10 = 9;
  localparam int P_01_11 = 10;
  localparam int P_02_12 = 11;
  localparam int P_12_12 = 12;
  localparam int P_02_02 = 13;

  localparam logic [2:0] PROD_A [NPROD] = '{
    H00, H10, H00, H10, H01, H11, H20, H21, H20, H00, H01, H02, H12, H02};
  localparam logic [2:0] PROD_B [NPROD] = '{
    H01, H11, H00, H10, H01, H11, H21, H21, H20, H10, H11, H12, H12, H02};

  // numerators and denominators of one camera
  typedef struct packed {
    logic signed [TW-1:0] n1;
    logic signed [TW-1:0] d1;
    logic signed [TW-1:0] n2;
    logic signed [TW-1:0] d2;
  } cam_terms_t;

  typedef struct packed {
    cam_terms_t fst;
    cam_terms_t snd;
  } terms_t;

endpackage
`default_nettype wire

// ===== hw/rtl/focals_from_homography.sv =====
// Focal lengths of two cameras from a homography.
// Input word: the first eight entries of a 3x3 homography, row-major,
// signed Q12.36, packed in in_tdata from h_00 up. Output word: both focal
// lengths as unsigned Q16.16 in out_tdata and their found flags in
// out_tuser; a focal length that was not found reads as zero.
// The block is one pipeline of 102 register stages: three for the products
// and terms, two for magnitudes and overflow checks, 64 for the four
// restoring dividers (one quotient bit per stage), one for candidate
// selection and 32 for the two square-root units (one root bit per stage).
// One word is taken every cycle while the output side takes words.
// When the receiver stalls with a word waiting, the whole pipeline holds
// and in_tready drops; nothing is lost or repeated. Reset empties the
// pipeline (all valid bits cleared); data registers are not reset.
`default_nettype none
module focals_from_homography (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // h_00, h_01, h_02, h_10, h_11, h_12, h_20, h_21 (48 bits each)
  input  wire logic [383:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // focal_first [31:0], focal_second [63:32]
  output logic [63:0]       out_tdata,
  // first_valid [0], second_valid [1]
  output logic [1:0]        out_tuser
);

  localparam int LAT = fhm_pkg::LAT;
  localparam int MW  = fhm_pkg::MW;
  localparam int TW  = fhm_pkg::TW;
  localparam int QW  = fhm_pkg::QW;

  typedef struct packed {
    logic [3:0] pos;
    logic [1:0] dgt;
  } side_t;

  logic [LAT-1:0]   vld_r;
  logic             adv;
  fhm_pkg::terms_t  terms;
  logic signed [TW-1:0] n_s [4];
  logic signed [TW-1:0] d_s [4];
  logic [MW-1:0]    magn_r [4];
  logic [MW-1:0]    magd_r [4];
  logic [3:0]       pos_r;
  logic [MW-1:0]    num5_r [4];
  logic [MW-1:0]    den5_r [4];
  logic [3:0]       sat5_r;
  side_t            side5_r;
  side_t            side_r [fhm_pkg::DIV_STAGES];
  logic [QW-1:0]    quo [4];
  logic [QW-1:0]    pick_r [2];
  logic [1:0]       ok6_r;
  logic [1:0]       ok_r [fhm_pkg::SQ_STAGES];
  logic [fhm_pkg::FW-1:0] root [2];

  // the pipeline moves unless a finished word is waiting
  assign adv       = out_tready || !out_tvalid;
  assign in_tready = adv;

  // valid bits travel beside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // products and terms
  fhm_front u_front (
    .clk    (clk),
    .en     (adv),
    .h_flat (in_tdata),
    .terms  (terms)
  );

  // candidates: first camera 0 and 1, second camera 2 and 3
  always_comb begin
    n_s[0] = terms.fst.n1;  d_s[0] = terms.fst.d1;
    n_s[1] = terms.fst.n2;  d_s[1] = terms.fst.d2;
    n_s[2] = terms.snd.n1;  d_s[2] = terms.snd.d1;
    n_s[3] = terms.snd.n2;  d_s[3] = terms.snd.d2;
  end

  for (genvar c = 0; c < 4; c++) begin : g_cand
    logic signed [TW-1:0] nneg, dneg;
    assign nneg = -n_s[c];
    assign dneg = -d_s[c];

    // magnitudes and positive test
    always_ff @(posedge clk) begin
      if (adv) begin
        magn_r[c] <= n_s[c][TW-1] ? nneg[MW-1:0] : n_s[c][MW-1:0];
        magd_r[c] <= d_s[c][TW-1] ? dneg[MW-1:0] : d_s[c][MW-1:0];
        pos_r[c]  <= (n_s[c] != '0) && (d_s[c] != '0) && (n_s[c][TW-1] == d_s[c][TW-1]);
      end
    end

    // quotient overflow check ahead of the divider
    always_ff @(posedge clk) begin
      if (adv) begin
        num5_r[c] <= magn_r[c];
        den5_r[c] <= magd_r[c];
        sat5_r[c] <= ({fhm_pkg::DIV_SH'(0), magn_r[c]} >=
                      {magd_r[c], fhm_pkg::DIV_SH'(0)});
      end
    end

    fhm_div u_div (
      .clk (clk),
      .en  (adv),
      .num (num5_r[c]),
      .den (den5_r[c]),
      .sat (sat5_r[c]),
      .quo (quo[c])
    );
  end

  // flags for the selection, alongside the dividers
  always_ff @(posedge clk) begin
    if (adv) begin
      side5_r.pos    <= pos_r;
      side5_r.dgt[0] <= magd_r[0] > magd_r[1];
      side5_r.dgt[1] <= magd_r[2] > magd_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side5_r;
      for (int k = 1; k < fhm_pkg::DIV_STAGES; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // choose one candidate per camera
  for (genvar m = 0; m < 2; m++) begin : g_cam
    logic          p1, p2, gt;
    logic [QW-1:0] q1, q2, big, sml;
    assign p1  = side_r[fhm_pkg::DIV_STAGES-1].pos[2*m];
    assign p2  = side_r[fhm_pkg::DIV_STAGES-1].pos[2*m+1];
    assign q1  = quo[2*m];
    assign q2  = quo[2*m+1];
    assign gt  = q1 > q2;
    assign big = gt ? q1 : q2;
    assign sml = gt ? q2 : q1;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (p1 && p2) begin
          pick_r[m] <= side_r[fhm_pkg::DIV_STAGES-1].dgt[m] ? big : sml;
        end else if (p1) begin
          pick_r[m] <= q1;
        end else begin
          pick_r[m] <= q2;
        end
        ok6_r[m] <= p1 || p2;
      end
    end

    fhm_sqrt u_sqrt (
      .clk  (clk),
      .en   (adv),
      .rad  (pick_r[m]),
      .root (root[m])
    );
  end

  // found flags alongside the square-root units
  always_ff @(posedge clk) begin
    if (adv) begin
      ok_r[0] <= ok6_r;
      for (int k = 1; k < fhm_pkg::SQ_STAGES; k++) begin
        ok_r[k] <= ok_r[k-1];
      end
    end
  end

  // output word
  assign out_tvalid       = vld_r[LAT-1];
  assign out_tuser        = ok_r[fhm_pkg::SQ_STAGES-1];
  assign out_tdata[31:0]  = out_tuser[0] ? root[0] : '0;
  assign out_tdata[63:32] = out_tuser[1] ? root[1] : '0;

  // reset leaves the pipeline empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("word present right after reset");

  // a stall freezes every valid bit
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved during a stall");

  // an empty output never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with no word waiting");

endmodule
`default_nettype wire

// ===== hw/rtl/fhm_front.sv =====
`default_nettype none
module fhm_front (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic [fhm_pkg::NH*fhm_pkg::HW-1:0]    h_flat,
  output fhm_pkg::terms_t                            terms
);

  logic signed [fhm_pkg::HW-1:0]  h [fhm_pkg::NH];
  logic signed [fhm_pkg::PPW-1:0] hh_r [fhm_pkg::NPROD];
  logic signed [fhm_pkg::PPW-1:0] hl_r [fhm_pkg::NPROD];
  logic signed [fhm_pkg::PPW-1:0] lh_r [fhm_pkg::NPROD];
  logic signed [fhm_pkg::PPW-1:0] ll_r [fhm_pkg::NPROD];
  logic signed [fhm_pkg::TW-1:0]  prod_r [fhm_pkg::NPROD];
  fhm_pkg::terms_t                terms_r;

  // unpack the entries
  always_comb begin
    for (int i = 0; i < fhm_pkg::NH; i++) begin
      h[i] = h_flat[i*fhm_pkg::HW +: fhm_pkg::HW];
    end
  end

  // stage 1: four half-width partial products per product
  for (genvar p = 0; p < fhm_pkg::NPROD; p++) begin : g_prod
    logic signed [fhm_pkg::HALF:0] ah, al, bh, bl;
    assign ah = {h[fhm_pkg::PROD_A[p]][fhm_pkg::HW-1],
                 h[fhm_pkg::PROD_A[p]][fhm_pkg::HW-1:fhm_pkg::HALF]};
    assign al = {1'b0, h[fhm_pkg::PROD_A[p]][fhm_pkg::HALF-1:0]};
    assign bh = {h[fhm_pkg::PROD_B[p]][fhm_pkg::HW-1],
                 h[fhm_pkg::PROD_B[p]][fhm_pkg::HW-1:fhm_pkg::HALF]};
    assign bl = {1'b0, h[fhm_pkg::PROD_B[p]][fhm_pkg::HALF-1:0]};

    always_ff @(posedge clk) begin
      if (en) begin
        hh_r[p] <= ah * bh;
        hl_r[p] <= ah * bl;
        lh_r[p] <= al * bh;
        ll_r[p] <= al * bl;
      end
    end

    // stage 2: weigh and add the partial products
    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[p] <= (fhm_pkg::TW'(hh_r[p]) <<< (2*fhm_pkg::HALF))
                   + (fhm_pkg::TW'(hl_r[p]) <<< fhm_pkg::HALF)
                   + (fhm_pkg::TW'(lh_r[p]) <<< fhm_pkg::HALF)
                   + fhm_pkg::TW'(ll_r[p]);
      end
    end
  end

  // stage 3: numerators and denominators of both cameras
  always_ff @(posedge clk) begin
    if (en) begin
      terms_r.snd.d1 <= prod_r[fhm_pkg::P_20_21];
      terms_r.snd.d2 <= prod_r[fhm_pkg::P_21_21] - prod_r[fhm_pkg::P_20_20];
      terms_r.snd.n1 <= -(prod_r[fhm_pkg::P_00_01] + prod_r[fhm_pkg::P_10_11]);
      terms_r.snd.n2 <= prod_r[fhm_pkg::P_00_00] + prod_r[fhm_pkg::P_10_10]
                      - prod_r[fhm_pkg::P_01_01] - prod_r[fhm_pkg::P_11_11];
      terms_r.fst.d1 <= prod_r[fhm_pkg::P_00_10] + prod_r[fhm_pkg::P_01_11];
      terms_r.fst.d2 <= prod_r[fhm_pkg::P_00_00] + prod_r[fhm_pkg::P_01_01]
                      - prod_r[fhm_pkg::P_10_10] - prod_r[fhm_pkg::P_11_11];
      terms_r.fst.n1 <= -prod_r[fhm_pkg::P_02_12];
      terms_r.fst.n2 <= prod_r[fhm_pkg::P_12_12] - prod_r[fhm_pkg::P_02_02];
    end
  end

  assign terms = terms_r;

endmodule
`default_nettype wire

// ===== hw/rtl/fhm_div.sv =====
`default_nettype none
module fhm_div (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [fhm_pkg::MW-1:0]   num,
  input  wire logic [fhm_pkg::MW-1:0]   den,
  input  wire logic                     sat,
  output logic      [fhm_pkg::QW-1:0]   quo
);

  localparam int N = fhm_pkg::DIV_STAGES;

  logic [fhm_pkg::MW-1:0] rem_i [N];
  logic [fhm_pkg::MW-1:0] den_i [N];
  logic [fhm_pkg::QW-1:0] lo_i  [N];
  logic [fhm_pkg::QW-1:0] q_i   [N];
  logic                   sat_i [N];
  logic [fhm_pkg::MW-1:0] rem_r [N];
  logic [fhm_pkg::MW-1:0] den_r [N];
  logic [fhm_pkg::QW-1:0] lo_r  [N];
  logic [fhm_pkg::QW-1:0] q_r   [N];
  logic                   sat_r [N];

  // stage inputs: the first stage starts from the top of the shifted numerator
  always_comb begin
    rem_i[0] = fhm_pkg::MW'(num[fhm_pkg::MW-1:fhm_pkg::DIV_SH]);
    den_i[0] = den;
    lo_i[0]  = {num[fhm_pkg::DIV_SH-1:0], {fhm_pkg::DIV_SH{1'b0}}};
    q_i[0]   = '0;
    sat_i[0] = sat;
    for (int k = 1; k < N; k++) begin
      rem_i[k] = rem_r[k-1];
      den_i[k] = den_r[k-1];
      lo_i[k]  = lo_r[k-1];
      q_i[k]   = q_r[k-1];
      sat_i[k] = sat_r[k-1];
    end
  end

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [fhm_pkg::MW:0] trial, dz, diff;
    logic                 ge;
    assign trial = {rem_i[k], lo_i[k][fhm_pkg::QW-1]};
    assign dz    = {1'b0, den_i[k]};
    assign diff  = trial - dz;
    assign ge    = (trial >= dz);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[fhm_pkg::MW-1:0] : trial[fhm_pkg::MW-1:0];
        den_r[k] <= den_i[k];
        lo_r[k]  <= {lo_i[k][fhm_pkg::QW-2:0], 1'b0};
        q_r[k]   <= {q_i[k][fhm_pkg::QW-2:0], ge};
        sat_r[k] <= sat_i[k];
      end
    end
  end

  assign quo = sat_r[N-1] ? '1 : q_r[N-1];

endmodule
`default_nettype wire

// ===== hw/rtl/fhm_sqrt.sv =====
`default_nettype none
module fhm_sqrt (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [fhm_pkg::QW-1:0]   rad,
  output logic      [fhm_pkg::FW-1:0]   root
);

  localparam int N = fhm_pkg::SQ_STAGES;

  logic [fhm_pkg::SRW-1:0] rem_i  [N];
  logic [fhm_pkg::FW-1:0]  root_i [N];
  logic [fhm_pkg::QW-1:0]  rest_i [N];
  logic [fhm_pkg::SRW-1:0] rem_r  [N];
  logic [fhm_pkg::FW-1:0]  root_r [N];
  logic [fhm_pkg::QW-1:0]  rest_r [N];

  // stage inputs
  always_comb begin
    rem_i[0]  = '0;
    root_i[0] = '0;
    rest_i[0] = rad;
    for (int k = 1; k < N; k++) begin
      rem_i[k]  = rem_r[k-1];
      root_i[k] = root_r[k-1];
      rest_i[k] = rest_r[k-1];
    end
  end

  // one root bit per stage from two radicand bits
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [fhm_pkg::SRW+1:0] trial, sub, diff;
    logic                    ge;
    assign trial = {rem_i[k], rest_i[k][fhm_pkg::QW-1:fhm_pkg::QW-2]};
    assign sub   = {2'b00, root_i[k], 2'b01};
    assign diff  = trial - sub;
    assign ge    = (trial >= sub);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[fhm_pkg::SRW-1:0] : trial[fhm_pkg::SRW-1:0];
        root_r[k] <= {root_i[k][fhm_pkg::FW-2:0], ge};
        rest_r[k] <= {rest_i[k][fhm_pkg::QW-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[N-1];

endmodule
`default_nettype wire
